>>> hdl/mppt_sweep_perturb_observe_defines.svh
// Assertion macros for the RTL; mpspo_ctrl.sv is the file that uses them.
// Each use names a label and a property; clk and rst_n come from the module.
`ifndef MPPT_SWEEP_PERTURB_OBSERVE_DEFINES_SVH
`define MPPT_SWEEP_PERTURB_OBSERVE_DEFINES_SVH

`ifndef SYNTHESIS

// Checked only out of reset.
`define MPSPO_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mpspo assertion failed");

// Checked on every edge, reset included.
`define MPSPO_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("mpspo assertion failed");

`else

`define MPSPO_ASSERT(lbl, prop)
`define MPSPO_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

>>> hdl/mpspo_pkg.sv
`default_nettype none

package mpspo_pkg;

  localparam int ADC_BITS = 12;
  localparam int DUTY_W   = 10;
  localparam int POWER_W  = 2 * ADC_BITS;
  localparam int MODE_W   = 3;

  typedef logic [ADC_BITS-1:0] code_t;
  typedef logic [DUTY_W-1:0]   duty_t;
  typedef logic [POWER_W-1:0]  power_t;

  // word kinds
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PV_MIN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_THR = 2'd1;
  localparam code_t PV_MIN_RESET   = 12'd1392;
  localparam code_t RECT_THR_RESET = 12'd410;

  // timing and duty constants
  localparam duty_t       PWM_PERIOD     = 10'd1000;
  localparam logic [6:0]  BOOT_LIMIT     = 7'd100;
  localparam duty_t       BOOT_DUTY      = 10'd150;
  localparam logic [8:0]  SWEEP_INTERVAL = 9'd300;
  localparam duty_t       SWEEP_END      = 10'd900;
  localparam logic [10:0] HOLD_LIMIT     = 11'd1500;
  localparam logic [6:0]  TRACK_INTERVAL = 7'd75;
  localparam duty_t       TRACK_CAP      = 10'd950;
  localparam logic [9:0]  CHECK_RESET    = 10'd15;
  localparam logic [9:0]  CHECK_MAX      = 10'd900;
  localparam logic [5:0]  BACKOFF_MAX    = 6'd60;
  localparam logic [5:0]  BACKOFF_RESET  = 6'd1;
  localparam logic [9:0]  QUARTER_HOUR   = 10'd900;

  typedef enum logic [4:0] {
    MODE_STANDBY = 5'b00001,
    MODE_BOOT    = 5'b00010,
    MODE_SWEEP   = 5'b00100,
    MODE_HOLD    = 5'b01000,
    MODE_TRACK   = 5'b10000
  } mode_t;

  // external mode codes
  localparam logic [MODE_W-1:0] MODE_CODE_STANDBY = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CODE_BOOT    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CODE_SWEEP   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CODE_HOLD    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CODE_TRACK   = 3'd4;

  typedef struct packed {
    logic  kind;
    code_t bat_voltage;
    code_t bat_current;
    code_t pv_average;
  } item_t;

  typedef struct packed {
    duty_t              main_compare;
    logic [DUTY_W-2:0]  trigger_compare;
    duty_t              rect_compare;
    logic               pwm_running;
    logic [MODE_W-1:0]  mode;
    logic               pv_present;
  } result_t;

  typedef struct packed {
    code_t pv_min;
    code_t rect_thr;
  } cfg_t;

  function automatic logic [MODE_W-1:0] mode_code(input mode_t m);
    logic [MODE_W-1:0] c;
    unique case (m)
      MODE_STANDBY: c = MODE_CODE_STANDBY;
      MODE_BOOT:    c = MODE_CODE_BOOT;
      MODE_SWEEP:   c = MODE_CODE_SWEEP;
      MODE_HOLD:    c = MODE_CODE_HOLD;
      MODE_TRACK:   c = MODE_CODE_TRACK;
      default:      c = MODE_CODE_STANDBY;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hdl/mpspo_ctrl.sv
`default_nettype none
`include "mppt_sweep_perturb_observe_defines.svh"

// Controller state and its combinational update for one word, registered on adv.
module mpspo_ctrl import mpspo_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    adv,
  input  wire item_t   item,
  input  wire cfg_t    cfg,
  output result_t      res
);

  mode_t       mode_r, mode_nxt;
  duty_t       duty_r, duty_nxt;
  duty_t       best_duty_r, best_duty_nxt;
  power_t      best_power_r, best_power_nxt;
  logic [6:0]  boot_wait_r, boot_wait_nxt;
  logic [8:0]  sweep_wait_r, sweep_wait_nxt;
  logic [10:0] hold_wait_r, hold_wait_nxt;
  logic [6:0]  track_wait_r, track_wait_nxt;
  power_t      prev_power_r, prev_power_nxt;
  logic        step_down_r, step_down_nxt;
  logic [9:0]  second_count_r, second_count_nxt;
  logic [9:0]  quarter_r, quarter_nxt;
  logic [9:0]  check_delay_r, check_delay_nxt;
  logic [5:0]  backoff_r, backoff_nxt;
  logic        clocks_on_r, clocks_on_nxt;
  logic        panel_ok_r, panel_ok_nxt;
  duty_t       main_written_r, main_written_nxt;
  duty_t       rect_written_r, rect_written_nxt;

  power_t             power;
  logic signed [11:0] dw;
  logic               sd;
  logic [9:0]         sc;
  logic [9:0]         qc;
  logic [9:0]         cd15;

  assign power = power_t'(item.bat_voltage) * power_t'(item.bat_current);

  always_comb begin
    mode_nxt         = mode_r;
    duty_nxt         = duty_r;
    best_duty_nxt    = best_duty_r;
    best_power_nxt   = best_power_r;
    boot_wait_nxt    = boot_wait_r;
    sweep_wait_nxt   = sweep_wait_r;
    hold_wait_nxt    = hold_wait_r;
    track_wait_nxt   = track_wait_r;
    prev_power_nxt   = prev_power_r;
    step_down_nxt    = step_down_r;
    second_count_nxt = second_count_r;
    quarter_nxt      = quarter_r;
    check_delay_nxt  = check_delay_r;
    backoff_nxt      = backoff_r;
    clocks_on_nxt    = clocks_on_r;
    panel_ok_nxt     = panel_ok_r;
    main_written_nxt = main_written_r;
    rect_written_nxt = rect_written_r;
    dw   = $signed({2'b00, duty_r});
    sd   = step_down_r;
    sc   = second_count_r + 10'd1;
    qc   = quarter_r + 10'd1;
    cd15 = ({4'b0000, backoff_r} << 4) - {4'b0000, backoff_r};

    if (item.kind == KIND_SAMPLE) begin
      unique case (mode_r)
        MODE_BOOT: begin
          boot_wait_nxt = boot_wait_r + 7'd1;
          if (boot_wait_nxt > BOOT_LIMIT) begin
            mode_nxt      = MODE_SWEEP;
            dw            = $signed({2'b00, BOOT_DUTY});
            boot_wait_nxt = '0;
          end
        end
        MODE_SWEEP: begin
          sweep_wait_nxt = sweep_wait_r + 9'd1;
          if (sweep_wait_nxt >= SWEEP_INTERVAL) begin
            sweep_wait_nxt = '0;
            if (power > best_power_r) begin
              best_duty_nxt  = duty_r;
              best_power_nxt = power;
            end
            dw = dw + 12'sd1;
            if (dw > $signed({2'b00, SWEEP_END})) begin
              mode_nxt       = MODE_HOLD;
              dw             = $signed({2'b00, best_duty_nxt});
              best_duty_nxt  = '0;
              best_power_nxt = '0;
            end
          end
        end
        MODE_HOLD: begin
          hold_wait_nxt = hold_wait_r + 11'd1;
          if (hold_wait_nxt > HOLD_LIMIT) begin
            mode_nxt      = MODE_TRACK;
            hold_wait_nxt = '0;
          end
        end
        MODE_TRACK: begin
          track_wait_nxt = track_wait_r + 7'd1;
          if (track_wait_nxt >= TRACK_INTERVAL) begin
            track_wait_nxt = '0;
            sd = step_down_r ^ (power < prev_power_r);
            step_down_nxt = sd;
            dw = sd ? dw - 12'sd1 : dw + 12'sd1;
            if (dw > $signed({2'b00, TRACK_CAP}))
              dw = $signed({2'b00, TRACK_CAP});
            prev_power_nxt = power;
          end
        end
        MODE_STANDBY: begin
        end
        default: begin
        end
      endcase

      if (dw > $signed({2'b00, PWM_PERIOD}))
        dw = $signed({2'b00, PWM_PERIOD});
      if (dw < 12'sd0)
        dw = 12'sd0;
      duty_nxt         = dw[DUTY_W-1:0];
      main_written_nxt = duty_nxt;
      // rectifier only follows duty with enough current, never in bootstrap
      if (mode_nxt != MODE_BOOT && item.bat_current > cfg.rect_thr)
        rect_written_nxt = duty_nxt;
      else
        rect_written_nxt = PWM_PERIOD;
    end else begin
      second_count_nxt = sc;
      quarter_nxt      = qc;
      if (sc > check_delay_r) begin
        second_count_nxt = '0;
        if (mode_r == MODE_STANDBY) begin
          clocks_on_nxt = 1'b0;
          if (item.pv_average > cfg.pv_min) begin
            panel_ok_nxt    = 1'b1;
            mode_nxt        = MODE_BOOT;
            duty_nxt        = '0;
            check_delay_nxt = '0;
            backoff_nxt     = BACKOFF_RESET;
            clocks_on_nxt   = 1'b1;
          end else begin
            panel_ok_nxt = 1'b0;
            backoff_nxt  = backoff_r + 6'd1;
            if (cd15 > CHECK_MAX) begin
              check_delay_nxt = CHECK_MAX;
              backoff_nxt     = BACKOFF_MAX;
            end else begin
              check_delay_nxt = cd15;
            end
            mode_nxt = MODE_STANDBY;
          end
        end
      end
      if (qc > QUARTER_HOUR) begin
        mode_nxt    = MODE_STANDBY;
        quarter_nxt = '0;
      end
    end

    res.main_compare    = main_written_nxt;
    res.trigger_compare = main_written_nxt[DUTY_W-1:1];
    res.rect_compare    = rect_written_nxt;
    res.pwm_running     = clocks_on_nxt;
    res.mode            = mode_code(mode_nxt);
    res.pv_present      = panel_ok_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= MODE_STANDBY;
      duty_r         <= '0;
      best_duty_r    <= '0;
      best_power_r   <= '0;
      boot_wait_r    <= '0;
      sweep_wait_r   <= '0;
      hold_wait_r    <= '0;
      track_wait_r   <= '0;
      prev_power_r   <= '0;
      step_down_r    <= 1'b0;
      second_count_r <= '0;
      quarter_r      <= '0;
      check_delay_r  <= CHECK_RESET;
      backoff_r      <= BACKOFF_RESET;
      clocks_on_r    <= 1'b1;
      panel_ok_r     <= 1'b0;
      main_written_r <= '0;
      rect_written_r <= PWM_PERIOD;
    end else if (adv) begin
      mode_r         <= mode_nxt;
      duty_r         <= duty_nxt;
      best_duty_r    <= best_duty_nxt;
      best_power_r   <= best_power_nxt;
      boot_wait_r    <= boot_wait_nxt;
      sweep_wait_r   <= sweep_wait_nxt;
      hold_wait_r    <= hold_wait_nxt;
      track_wait_r   <= track_wait_nxt;
      prev_power_r   <= prev_power_nxt;
      step_down_r    <= step_down_nxt;
      second_count_r <= second_count_nxt;
      quarter_r      <= quarter_nxt;
      check_delay_r  <= check_delay_nxt;
      backoff_r      <= backoff_nxt;
      clocks_on_r    <= clocks_on_nxt;
      panel_ok_r     <= panel_ok_nxt;
      main_written_r <= main_written_nxt;
      rect_written_r <= rect_written_nxt;
    end
  end

  `MPSPO_ASSERT(a_duty_in_range, duty_r <= PWM_PERIOD)
  `MPSPO_ASSERT(a_tick_keeps_main, adv && item.kind == KIND_TICK |=> $stable(main_written_r))
  `MPSPO_ASSERT(a_clocks_off_standby, !clocks_on_r |-> mode_r == MODE_STANDBY)
  `MPSPO_ASSERT(a_backoff_range, backoff_r >= BACKOFF_RESET && backoff_r <= BACKOFF_MAX + 6'd1)

endmodule

`default_nettype wire

>>> hdl/mppt_sweep_perturb_observe.sv
// Solar MPPT duty controller. Each input word is either a converter sample
// (tuser 0: battery voltage and current) or a one-second tick (tuser 1:
// average panel voltage). Every word yields exactly one result word with the
// switch, trigger and rectifier compares, the modulator enable, the mode
// (0 standby, 1 bootstrap, 2 sweep, 3 hold, 4 perturb-and-observe) and the
// panel-present flag. Throughput is one word per clock while out_tready stays
// high. The update (12x12 power multiply plus mode logic) is combinational
// and sits between the input register and the result register. Ticks run the
// panel check with backoff while in standby and force standby once the quarter-hour
// tick count passes 900. The user must write thresholds through the cfg port only
// while no word is in flight (the block does not enforce it); index 0 is the panel
// voltage minimum, 1 the rectifier current threshold, other indexes are ignored.
`default_nettype none

module mppt_sweep_perturb_observe import mpspo_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input stream
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [39:0]          in_tdata,  // bat_voltage, bat_current, pv_average, pad
  input  wire logic                 in_tuser,  // kind
  // result stream
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [39:0]               out_tdata, // main, trigger, rect, pwm_running,
                                               // mode, pv_present, pad
  // configuration
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ADC_BITS-1:0]  cfg_wdata
);

  // input register stage
  logic    s1_valid_r, s1_valid_nxt;
  item_t   s1_item_r;
  // result register
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;
  result_t res;
  cfg_t    cfg_r;
  logic    out_free;
  logic    adv;
  logic    in_acc;

  assign out_free  = !out_valid_r || out_tready;
  assign adv       = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc)
      s1_valid_nxt = 1'b1;
    else if (adv)
      s1_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (adv)
      out_valid_nxt = 1'b1;
    else if (out_tready)
      out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      cfg_r.pv_min   <= PV_MIN_RESET;
      cfg_r.rect_thr <= RECT_THR_RESET;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_PV_MIN)
          cfg_r.pv_min <= cfg_wdata;
        else if (cfg_index == CFG_RECT_THR)
          cfg_r.rect_thr <= cfg_wdata;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r.kind        <= in_tuser;
      s1_item_r.bat_voltage <= in_tdata[11:0];
      s1_item_r.bat_current <= in_tdata[23:12];
      s1_item_r.pv_average  <= in_tdata[35:24];
    end
    if (adv)
      out_res_r <= res;
  end

  mpspo_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .item  (s1_item_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b000000,
                       out_res_r.pv_present,
                       out_res_r.mode,
                       out_res_r.pwm_running,
                       out_res_r.rect_compare,
                       out_res_r.trigger_compare,
                       out_res_r.main_compare};

endmodule

`default_nettype wire

>>> verif/mppt_duty_checker.sv
`timescale 1ns / 1ps

// Watches both streams and the cfg port, keeps its own copy of the controller
// state and checks every result word against the oldest expectation.
module mppt_duty_checker
  import mpspo_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [39:0]          in_tdata,   // bat_voltage, bat_current, pv_average, pad
  input  logic                 in_tuser,   // kind
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [39:0]          out_tdata,  // main, trigger, rect, pwm_running,
                                           // mode, pv_present, pad
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADC_BITS-1:0]  cfg_wdata,
  input  logic                 end_check,
  output int                   fail_count,
  output int                   words_out,
  output logic [MODE_W-1:0]    mode_now
);

  localparam int CHECK_UNIT = 15;

  code_t             pv_min;
  code_t             rect_thr;
  logic [MODE_W-1:0] mode_q;
  duty_t             duty;
  duty_t             best_duty;
  power_t            best_power;
  power_t            prev_power;
  logic [6:0]        boot_wait;
  logic [8:0]        sweep_wait;
  logic [10:0]       hold_wait;
  logic [6:0]        track_wait;
  logic              step_down;
  logic [9:0]        sec_count;
  logic [9:0]        qh_count;
  logic [9:0]        check_delay;
  logic [5:0]        backoff;
  logic              clocks_on;
  logic              panel_ok;
  duty_t             main_w;
  logic [DUTY_W-2:0] trig_w;
  duty_t             rect_w;

  result_t due_results[$];
  int      bad_words = 0;
  logic    end_done = 1'b0;

  task automatic clear_controller();
    pv_min      = PV_MIN_RESET;
    rect_thr    = RECT_THR_RESET;
    mode_q      = MODE_CODE_STANDBY;
    duty        = '0;
    best_duty   = '0;
    best_power  = '0;
    prev_power  = '0;
    boot_wait   = '0;
    sweep_wait  = '0;
    hold_wait   = '0;
    track_wait  = '0;
    step_down   = 1'b0;
    sec_count   = '0;
    qh_count    = '0;
    check_delay = CHECK_RESET;
    backoff     = BACKOFF_RESET;
    clocks_on   = 1'b1;
    panel_ok    = 1'b0;
    main_w      = '0;
    trig_w      = '0;
    rect_w      = PWM_PERIOD;
  endtask

  task automatic check_panel(input code_t pv);
    int delay;
    clocks_on = 1'b0;
    if (pv > pv_min) begin
      panel_ok    = 1'b1;
      mode_q      = MODE_CODE_BOOT;
      duty        = '0;
      check_delay = '0;
      backoff     = BACKOFF_RESET;
      clocks_on   = 1'b1;
    end else begin
      panel_ok = 1'b0;
      delay    = CHECK_UNIT * int'(backoff);
      backoff  = backoff + 1'b1;
      if (delay > int'(CHECK_MAX)) begin
        check_delay = CHECK_MAX;
        backoff     = BACKOFF_MAX;
      end else begin
        check_delay = delay[9:0];
      end
      mode_q = MODE_CODE_STANDBY;
    end
  endtask

  task automatic take_tick(input code_t pv);
    sec_count = sec_count + 1'b1;
    qh_count  = qh_count + 1'b1;
    if (sec_count > check_delay) begin
      sec_count = '0;
      if (mode_q == MODE_CODE_STANDBY) check_panel(pv);
    end
    if (qh_count > QUARTER_HOUR) begin
      mode_q   = MODE_CODE_STANDBY;
      qh_count = '0;
    end
  endtask

  task automatic take_sample(input code_t v, input code_t i);
    power_t p;
    int     next;
    p    = power_t'(v) * power_t'(i);
    next = int'(duty);
    case (mode_q)
      MODE_CODE_BOOT: begin
        boot_wait = boot_wait + 1'b1;
        if (boot_wait > BOOT_LIMIT) begin
          mode_q    = MODE_CODE_SWEEP;
          next      = int'(BOOT_DUTY);
          boot_wait = '0;
        end
      end
      MODE_CODE_SWEEP: begin
        sweep_wait = sweep_wait + 1'b1;
        if (sweep_wait >= SWEEP_INTERVAL) begin
          sweep_wait = '0;
          if (p > best_power) begin
            best_duty  = duty;
            best_power = p;
          end
          next = int'(duty) + 1;
          if (next > int'(SWEEP_END)) begin
            mode_q     = MODE_CODE_HOLD;
            next       = int'(best_duty);
            best_duty  = '0;
            best_power = '0;
          end
        end
      end
      MODE_CODE_HOLD: begin
        hold_wait = hold_wait + 1'b1;
        if (hold_wait > HOLD_LIMIT) begin
          mode_q    = MODE_CODE_TRACK;
          hold_wait = '0;
        end
      end
      MODE_CODE_TRACK: begin
        track_wait = track_wait + 1'b1;
        if (track_wait >= TRACK_INTERVAL) begin
          track_wait = '0;
          if (p < prev_power) step_down = !step_down;
          next = step_down ? int'(duty) - 1 : int'(duty) + 1;
          if (next > int'(TRACK_CAP)) next = int'(TRACK_CAP);
          prev_power = p;
        end
      end
      default: ;
    endcase
    if (next > int'(PWM_PERIOD)) next = int'(PWM_PERIOD);
    if (next < 0) next = 0;
    duty   = duty_t'(next);
    main_w = duty;
    trig_w = duty[DUTY_W-1:1];
    rect_w = (mode_q != MODE_CODE_BOOT && i > rect_thr) ? duty : PWM_PERIOD;
  endtask

  always @(posedge clk) begin : scoreboard
    result_t got;
    result_t want;
    if (!rst_n) begin
      clear_controller();
      due_results.delete();
      words_out <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PV_MIN:   pv_min   = cfg_wdata;
          CFG_RECT_THR: rect_thr = cfg_wdata;
          default: ;
        endcase
      end

      // result side first: a word leaving now belongs to an older input
      if (out_tvalid && out_tready) begin
        words_out <= words_out + 1;
        got.main_compare    = out_tdata[9:0];
        got.trigger_compare = out_tdata[18:10];
        got.rect_compare    = out_tdata[28:19];
        got.pwm_running     = out_tdata[29];
        got.mode            = out_tdata[32:30];
        got.pv_present      = out_tdata[33];
        if (due_results.size() == 0) begin
          if (bad_words < 10)
            $display("[%0t] result word with nothing pending: %h", $time, out_tdata);
          bad_words++;
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            if (bad_words < 10) begin
              $write("[%0t] mismatch exp main %0d trig %0d rect %0d run %b mode %0d pv %b",
                     $time, want.main_compare, want.trigger_compare,
                     want.rect_compare, want.pwm_running, want.mode, want.pv_present);
              $display(" | got main %0d trig %0d rect %0d run %b mode %0d pv %b",
                       got.main_compare, got.trigger_compare, got.rect_compare,
                       got.pwm_running, got.mode, got.pv_present);
            end
            bad_words++;
          end
        end
      end

      if (in_tvalid && in_tready) begin
        if (in_tuser == KIND_SAMPLE) take_sample(in_tdata[11:0], in_tdata[23:12]);
        else take_tick(in_tdata[35:24]);
        want.main_compare    = main_w;
        want.trigger_compare = trig_w;
        want.rect_compare    = rect_w;
        want.pwm_running     = clocks_on;
        want.mode            = mode_q;
        want.pv_present      = panel_ok;
        due_results.push_back(want);
      end

      if (end_check && !end_done) begin
        if (due_results.size() != 0)
          $display("[%0t] %0d result words never arrived", $time, due_results.size());
        bad_words += due_results.size();
        end_done  <= 1'b1;
      end
    end
    mode_now   <= mode_q;
    fail_count <= bad_words;
  end

endmodule

>>> verif/tb_mppt_sweep_perturb_observe.sv
`timescale 1ns / 1ps

module tb_mppt_sweep_perturb_observe;
  import mpspo_pkg::*;

  // cycle budget: ~1450 words plus one long receiver hold and a few drains,
  // with ample margin
  localparam int CYCLE_LIMIT    = 50_000;
  localparam int RX_HOLD_CYCLES = 400;   // long receiver hold-off
  localparam int SETTLE_CYCLES  = 8;     // settle time after the input and result registers empty
  localparam int PHASE_WORDS    = 150;   // words in each idling phase
  localparam int NIGHT_WORDS    = 900;   // tick-heavy, reaches the quarter hour
  localparam int DAY_WORDS      = 150;   // panel pass, bootstrap, sweep start
  localparam int TAIL_WORDS     = 80;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3; // no register here
  localparam code_t CODE_MAX = '1;

  logic                 clk        = 1'b0;
  logic                 rst_n      = 1'b0;
  logic                 in_tvalid  = 1'b0;
  logic                 in_tready;
  logic [39:0]          in_tdata   = '0;   // bat_voltage, bat_current, pv_average, pad
  logic                 in_tuser   = 1'b0; // kind
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [39:0]          out_tdata;         // main, trigger, rect, pwm_running,
                                           // mode, pv_present, pad
  logic                 cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index  = '0;
  logic [ADC_BITS-1:0]  cfg_wdata  = '0;

  logic                 end_check   = 1'b0;
  logic                 rx_hold_req = 1'b0;
  int                   fail_count;
  int                   words_out;
  logic [MODE_W-1:0]    mode_now;

  int    tx_idle_pct = 0;
  int    rx_idle_pct = 0;
  int    sent = 0;       // accepted input words
  code_t pv_floor = PV_MIN_RESET; // current panel threshold, for picking passing codes
  int unsigned cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  mppt_sweep_perturb_observe uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  mppt_duty_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .end_check (end_check),
    .fail_count(fail_count),
    .words_out (words_out),
    .mode_now  (mode_now)
  );

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side backpressure. A pulse on rx_hold_req drops tready for a long
  // stretch, counted here, so the block fills and pushes back on its input.
  initial begin : rx_drive
    int n;
    forever begin
      @(posedge clk);
      if (rx_hold_req) begin
        out_tready <= 1'b0;
        for (n = 0; n < RX_HOLD_CYCLES; n++) @(posedge clk);
      end
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // One input word; random sender gaps ahead of it, then hold until taken.
  task automatic send_word(input logic kind, input code_t v, input code_t i,
                           input code_t pv);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {4'b0, pv, i, v};
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  // Sender stops until every result word is back.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sent != words_out);
  endtask

  // Both thresholds plus a write to an unused index, always with nothing in flight.
  task automatic write_config(input code_t pv_min, input code_t rect_thr);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PV_MIN;
    cfg_wdata <= pv_min;
    @(posedge clk);
    cfg_index <= CFG_RECT_THR;
    cfg_wdata <= rect_thr;
    @(posedge clk);
    cfg_index <= CFG_SPARE;
    cfg_wdata <= code_t'($urandom);
    @(posedge clk);
    cfg_we   <= 1'b0;
    pv_floor = pv_min;
  endtask

  task automatic stall_receiver();
    in_tvalid   <= 1'b0;
    rx_hold_req <= 1'b1;
    @(posedge clk);
    rx_hold_req <= 1'b0;
  endtask

  // Mostly random codes, with the rails showing up often.
  function automatic code_t sample_code();
    case ($urandom_range(7))
      0:       return '0;
      1:       return CODE_MAX;
      default: return code_t'($urandom);
    endcase
  endfunction

  // A panel code that passes the check (rail if the threshold sits at the top).
  function automatic code_t panel_above();
    if (pv_floor == CODE_MAX) return CODE_MAX;
    return code_t'($urandom_range(int'(CODE_MAX), int'(pv_floor) + 1));
  endfunction

  // Random traffic: in standby mostly ticks so the panel check gets done,
  // elsewhere ticks at tick_pct percent, so low values keep the mode machine moving.
  task automatic send_mixed(input int tick_pct);
    code_t pv;
    if ($urandom_range(99) < ((mode_now == MODE_CODE_STANDBY) ? 80 : tick_pct)) begin
      pv = ($urandom_range(3) == 0) ? code_t'($urandom) : panel_above();
      send_word(KIND_TICK, code_t'($urandom), code_t'($urandom), pv);
    end else begin
      send_word(KIND_SAMPLE, sample_code(), sample_code(), code_t'($urandom));
    end
  endtask

  // Day: a passing panel ends standby, then bootstrap and the sweep. Sweep
  // samples carry full current and a voltage one code lower per 64 of them.
  task automatic walk_day();
    int sweep_k;
    int k;
    sweep_k = 0;
    for (k = 0; k < DAY_WORDS; k++) begin
      case (mode_now)
        MODE_CODE_STANDBY:
          send_word(KIND_TICK, code_t'($urandom), code_t'($urandom), panel_above());
        MODE_CODE_SWEEP: begin
          send_word(KIND_SAMPLE, code_t'(int'(CODE_MAX) - sweep_k / 64), CODE_MAX,
                    code_t'($urandom));
          sweep_k++;
        end
        default:
          send_word(KIND_SAMPLE, sample_code(), sample_code(), code_t'($urandom));
      endcase
    end
  endtask

  initial begin : stimulus
    int n;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed, reset thresholds ---
    // standby samples still rewrite the compares; current at and just above
    // the rectifier threshold; rails on both bat fields
    send_word(KIND_SAMPLE, CODE_MAX, CODE_MAX, '0);
    send_word(KIND_SAMPLE, '0, '0, CODE_MAX);
    send_word(KIND_SAMPLE, CODE_MAX, '0, '0);
    send_word(KIND_SAMPLE, '0, CODE_MAX, '0);
    send_word(KIND_SAMPLE, 12'd1234, RECT_THR_RESET, '0);
    send_word(KIND_SAMPLE, 12'd1234, RECT_THR_RESET + 1'b1, '0);
    // ticks up to the first check; pv ignored until then
    for (n = 0; n < 15; n++)
      send_word(KIND_TICK, code_t'($urandom), code_t'($urandom), n[0] ? CODE_MAX : '0);
    // panel exactly at threshold fails and starts the backoff
    send_word(KIND_TICK, CODE_MAX, CODE_MAX, PV_MIN_RESET);

    // --- phase A: sender idles 20%, receiver 67%; any nonzero panel code passes ---
    write_config('0, CODE_MAX);
    tx_idle_pct = 20;
    rx_idle_pct = 67;
    for (n = 0; n < PHASE_WORDS; n++) begin
      if (n == 50) stall_receiver();
      if (n == 100) drain();
      send_mixed(3);
    end

    // --- phase B: the other way round ---
    write_config(12'd2048, '0);
    tx_idle_pct = 67;
    rx_idle_pct = 20;
    for (n = 0; n < PHASE_WORDS; n++) send_mixed(3);

    // --- no idling from here on ---
    // night: panel never passes; the quarter-hour return to standby lands
    // near the end and the failed checks start the backoff
    write_config(CODE_MAX, 12'd2000);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (n = 0; n < NIGHT_WORDS; n++) begin
      if ($urandom_range(39) == 0)
        send_word(KIND_SAMPLE, sample_code(), sample_code(), code_t'($urandom));
      else
        send_word(KIND_TICK, code_t'($urandom), code_t'($urandom), code_t'($urandom));
    end

    // day: panel passes, bootstrap, sweep
    write_config(12'd1000, RECT_THR_RESET);
    walk_day();

    // tick-heavy tail with random thresholds
    write_config(code_t'($urandom_range(4094, 1)), code_t'($urandom));
    for (n = 0; n < TAIL_WORDS; n++) send_mixed(85);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    end_check <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/mpspo_pkg.sv
hdl/mpspo_ctrl.sv
hdl/mppt_sweep_perturb_observe.sv
verif/mppt_duty_checker.sv
verif/tb_mppt_sweep_perturb_observe.sv
